/* design/hrlc_pkg.sv */
// ----------------------------------------------------------------------------
// hrlc_pkg
// Types, codes and character tables shared by the request line checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlc_pkg;

    // Verdict reason codes
    typedef enum logic [2:0] {
        RS_OK       = 3'd0,
        RS_NO_SPACE = 3'd1,
        RS_METHOD   = 3'd2,
        RS_PATH     = 3'd3,
        RS_NO_SP2   = 3'd4,
        RS_VERSION  = 3'd5,
        RS_PRIOR    = 3'd6
    } t_reason;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [3:0] VERS_LEN  = 4'd9;
    localparam logic [2:0] IDX_SAT   = 3'd7;
    localparam logic [8:0] ST_NONE   = 9'd0;
    localparam logic [8:0] ST_400    = 9'd400;
    localparam logic [8:0] ST_405    = 9'd405;
    localparam logic [8:0] ST_505    = 9'd505;

    // Token length of each method: GET, POST, DELETE
    function automatic logic [2:0] meth_len(input logic [1:0] c);
        unique case (c)
            2'd0:    meth_len = 3'd3;
            2'd1:    meth_len = 3'd4;
            2'd2:    meth_len = 3'd6;
            default: meth_len = 3'd0;
        endcase
    endfunction

    // Character of method c at position idx (positions past the token give 0)
    function automatic logic [7:0] meth_char(input logic [1:0] c, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (c)
            2'd0: begin
                unique case (idx)
                    3'd0:    ch = "G";
                    3'd1:    ch = "E";
                    3'd2:    ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                unique case (idx)
                    3'd0:    ch = "P";
                    3'd1:    ch = "O";
                    3'd2:    ch = "S";
                    3'd3:    ch = "T";
                    default: ch = 8'h00;
                endcase
            end
            2'd2: begin
                unique case (idx)
                    3'd0:    ch = "D";
                    3'd1:    ch = "E";
                    3'd2:    ch = "L";
                    3'd3:    ch = "E";
                    3'd4:    ch = "T";
                    3'd5:    ch = "E";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        meth_char = ch;
    endfunction

    // Expected version text: HTTP/1.1 followed by CR
    function automatic logic [7:0] vers_char(input logic [3:0] idx);
        unique case (idx)
            4'd0:    vers_char = "H";
            4'd1:    vers_char = "T";
            4'd2:    vers_char = "T";
            4'd3:    vers_char = "P";
            4'd4:    vers_char = "/";
            4'd5:    vers_char = "1";
            4'd6:    vers_char = ".";
            4'd7:    vers_char = "1";
            4'd8:    vers_char = 8'h0D;
            default: vers_char = 8'h00;
        endcase
    endfunction

    // Missing-space reasons keep their code; others yield to a prior error
    function automatic t_reason fail_code(input t_reason r, input logic prior);
        if (r != RS_NO_SPACE && r != RS_NO_SP2 && prior) begin
            fail_code = RS_PRIOR;
        end else begin
            fail_code = r;
        end
    endfunction

    function automatic logic [8:0] status_of(input t_reason r);
        unique case (r)
            RS_NO_SPACE: status_of = ST_400;
            RS_METHOD:   status_of = ST_405;
            RS_PATH:     status_of = ST_400;
            RS_VERSION:  status_of = ST_505;
            default:     status_of = ST_NONE;
        endcase
    endfunction

endpackage

`default_nettype wire

/* design/http_request_line_checker_core.sv */
// ----------------------------------------------------------------------------
// http_request_line_checker_core
// Byte-serial HTTP request line checker with path slash collapsing.
// ----------------------------------------------------------------------------
// Latency: each result is registered and visible on the output in the cycle after its input transfer.
// Throughput: one byte per cycle; the single output register is the only
//   buffer, so the input stalls exactly while a held result is stalled.
// Reset (synchronous, active low): clears the output valid and re-arms the
//   parser at the method phase with the prior error flag cleared.
`default_nettype none

module http_request_line_checker_core
    import hrlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte input channel
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_line_byte,
    input  wire logic       i_end_of_line,
    input  wire logic       i_prior_error,
    // result channel
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_result_kind,
    output logic [7:0]      o_path_byte,
    output logic            o_accepted,
    output logic [2:0]      o_reason,
    output logic [8:0]      o_http_status,
    output logic [1:0]      o_method_code
);

    // Parse phase of the current line
    typedef enum logic [1:0] {
        PH_METHOD   = 2'd0,
        PH_PATH     = 2'd1,
        PH_PATH_BAD = 2'd2,
        PH_VERSION  = 2'd3
    } t_phase;

    // ---------------------------------------------------------------- state
    t_phase     r_phase,        n_phase;
    logic [2:0] r_method_index, n_method_index;  // token position, then method
    logic [2:0] r_cand,         n_cand;          // live method candidates
    logic       r_prev_slash,   n_prev_slash;
    logic       r_path_len,     n_path_len;      // path holds at least one byte
    logic [3:0] r_vers_index,   n_vers_index;
    t_reason    r_failure,      n_failure;
    logic       r_prior,        n_prior;
    logic       r_line_start,   n_line_start;
    logic       r_method_known, n_method_known;

    // Output register
    logic       r_out_valid;
    logic       r_kind;
    logic [7:0] r_path_byte;
    logic       r_accepted;
    t_reason    r_reason;
    logic [8:0] r_status;
    logic [1:0] r_method;

    // Combinational result for the byte on the input
    logic       w_in_xfer;
    logic       w_out_xfer;
    logic       w_res_valid;
    logic       w_res_kind;
    logic       w_emit;
    logic       w_found_ok;
    logic [1:0] w_found;
    t_reason    w_verdict;
    logic [1:0] w_method;

    // A held result blocks the input only while the consumer stalls it
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    // ------------------------------------------------------- per-byte logic
    always_comb begin
        n_phase        = r_phase;
        n_method_index = r_method_index;
        n_cand         = r_cand;
        n_prev_slash   = r_prev_slash;
        n_path_len     = r_path_len;
        n_vers_index   = r_vers_index;
        n_failure      = r_failure;
        n_method_known = r_method_known;
        n_line_start   = 1'b0;
        // The prior error flag is sampled on the first byte of each line
        n_prior        = r_line_start ? i_prior_error : r_prior;
        w_emit         = 1'b0;
        w_found_ok     = 1'b0;
        w_found        = 2'd0;
        w_verdict      = RS_OK;
        w_method       = 2'd0;

        // Once a line has failed, ignore everything up to its final byte
        if (r_failure == RS_OK) begin
            unique case (r_phase)
                PH_METHOD: begin
                    if (i_line_byte == CH_SPACE) begin
                        // Pick the live candidate whose length equals the count
                        for (int c = 0; c < 3; c++) begin
                            if (r_cand[c] && meth_len(2'(c)) == r_method_index) begin
                                w_found_ok = 1'b1;
                                w_found    = 2'(c);
                            end
                        end
                        if (!w_found_ok) begin
                            n_failure = fail_code(RS_METHOD, n_prior);
                        end else begin
                            n_method_index = {1'b0, w_found};
                            n_method_known = 1'b1;
                            n_phase        = PH_PATH;
                            n_path_len     = 1'b0;
                        end
                    end else begin
                        // Drop every candidate that this byte rules out
                        for (int c = 0; c < 3; c++) begin
                            if (!(r_method_index < meth_len(2'(c)) &&
                                  meth_char(2'(c), r_method_index) == i_line_byte)) begin
                                n_cand[c] = 1'b0;
                            end
                        end
                        if (r_method_index < IDX_SAT) begin
                            n_method_index = r_method_index + 3'd1;
                        end
                    end
                end
                PH_PATH, PH_PATH_BAD: begin
                    if (i_line_byte == CH_SPACE) begin
                        if (r_phase == PH_PATH_BAD || !r_path_len) begin
                            n_failure = fail_code(RS_PATH, n_prior);
                        end else begin
                            n_phase = PH_VERSION;
                        end
                    end else if (r_phase == PH_PATH && !r_path_len &&
                                 i_line_byte != CH_SLASH) begin
                        n_phase = PH_PATH_BAD;
                    end else if (r_phase == PH_PATH) begin
                        // Collapse each run of slashes to its first slash
                        n_path_len   = 1'b1;
                        w_emit       = !(i_line_byte == CH_SLASH && r_prev_slash);
                        n_prev_slash = (i_line_byte == CH_SLASH);
                    end
                end
                PH_VERSION: begin
                    if (r_vers_index >= VERS_LEN || vers_char(r_vers_index) != i_line_byte) begin
                        n_failure = fail_code(RS_VERSION, n_prior);
                    end else begin
                        n_vers_index = r_vers_index + 4'd1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        if (i_end_of_line) begin
            // Settle the verdict from the state after this byte
            w_verdict = n_failure;
            if (n_failure == RS_OK) begin
                priority if (n_phase == PH_METHOD) begin
                    w_verdict = RS_NO_SPACE;
                end else if (n_phase == PH_PATH || n_phase == PH_PATH_BAD) begin
                    w_verdict = RS_NO_SP2;
                end else if (n_vers_index != VERS_LEN) begin
                    w_verdict = fail_code(RS_VERSION, n_prior);
                end else begin
                    w_verdict = RS_OK;
                end
            end
            // Capture the method before the parser re-arms below
            w_method = n_method_known ? n_method_index[1:0] : 2'd0;
        end

        // A final byte never emits a path byte, only the verdict
        w_res_valid = i_end_of_line || w_emit;
        w_res_kind  = i_end_of_line;

        if (i_end_of_line) begin
            // Re-arm for the next line; the prior flag is re-sampled then
            n_phase        = PH_METHOD;
            n_method_index = 3'd0;
            n_cand         = 3'b111;
            n_prev_slash   = 1'b0;
            n_path_len     = 1'b0;
            n_vers_index   = 4'd0;
            n_failure      = RS_OK;
            n_method_known = 1'b0;
            n_line_start   = 1'b1;
        end
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_METHOD;
            r_method_index <= 3'd0;
            r_cand         <= 3'b111;
            r_prev_slash   <= 1'b0;
            r_path_len     <= 1'b0;
            r_vers_index   <= 4'd0;
            r_failure      <= RS_OK;
            r_prior        <= 1'b0;
            r_line_start   <= 1'b1;
            r_method_known <= 1'b0;
            r_out_valid    <= 1'b0;
            r_kind         <= 1'b0;
            r_path_byte    <= 8'h00;
            r_accepted     <= 1'b0;
            r_reason       <= RS_OK;
            r_status       <= ST_NONE;
            r_method       <= 2'd0;
        end else begin
            if (w_in_xfer) begin
                // Advance the parser on every byte transfer
                r_phase        <= n_phase;
                r_method_index <= n_method_index;
                r_cand         <= n_cand;
                r_prev_slash   <= n_prev_slash;
                r_path_len     <= n_path_len;
                r_vers_index   <= n_vers_index;
                r_failure      <= n_failure;
                r_prior        <= n_prior;
                r_line_start   <= n_line_start;
                r_method_known <= n_method_known;
            end
            // Load a new result, or drop the held one once it is taken
            if (w_in_xfer && w_res_valid) begin
                r_out_valid <= 1'b1;
                r_kind      <= w_res_kind;
                r_path_byte <= w_res_kind ? 8'h00 : i_line_byte;
                r_accepted  <= w_res_kind && (w_verdict == RS_OK);
                r_reason    <= w_res_kind ? w_verdict : RS_OK;
                r_status    <= w_res_kind ? status_of(w_verdict) : ST_NONE;
                r_method    <= w_res_kind ? w_method : 2'd0;
            end else if (w_out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_path_byte   = r_path_byte;
    assign o_accepted    = r_accepted;
    assign o_reason      = r_reason;
    assign o_http_status = r_status;
    assign o_method_code = r_method;

    // ----------------------------------------------------------- assertions
    // An accepted line carries no failure reason and no status
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind && r_accepted |-> r_reason == RS_OK && r_status == ST_NONE)
        else $error("accepted verdict with a reason or status");

    // A space never appears in the emitted path
    a_path_no_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_kind |-> r_path_byte != CH_SPACE)
        else $error("space emitted as a path byte");

    // The final byte of a line always re-arms the parser
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_end_of_line |=> r_line_start && r_phase == PH_METHOD &&
                                       r_failure == RS_OK)
        else $error("parser not re-armed after final byte");

    // A failed line produces no path byte before its final byte
    a_quiet_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && r_failure != RS_OK && !i_end_of_line |-> !w_res_valid)
        else $error("result produced after failure");

endmodule

`default_nettype wire

/* sim/hrlc_result_checker.sv */
// ----------------------------------------------------------------------------
// hrlc_result_checker
// Watches both channels of the request line checker, predicts the path bytes
// and verdicts from every byte transfer and compares each result in order.
// ----------------------------------------------------------------------------
module hrlc_result_checker
    import hrlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_line_byte,
    input  wire logic       i_end_of_line,
    input  wire logic       i_prior_error,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic       i_result_kind,
    input  wire logic [7:0] i_path_byte,
    input  wire logic       i_accepted,
    input  wire logic [2:0] i_reason,
    input  wire logic [8:0] i_http_status,
    input  wire logic [1:0] i_method_code,
    output int              o_fail_count,
    output int              o_results_due,
    output int              o_lines_seen,
    output int              o_lines_accepted,
    output int              o_path_bytes_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_METHOD   = 2'd0,
        PH_PATH     = 2'd1,
        PH_PATH_BAD = 2'd2,
        PH_VERSION  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        M_GET    = 2'd0,
        M_POST   = 2'd1,
        M_DELETE = 2'd2
    } t_method;

    localparam logic RK_PATH    = 1'b0;
    localparam logic RK_VERDICT = 1'b1;

    // Method tokens, left aligned; index 0 GET, 1 POST, 2 DELETE
    localparam logic [2:0][47:0] TOKEN_TEXT = {"DELETE", {"POST", 16'h0}, {"GET", 24'h0}};
    localparam logic [2:0][2:0]  TOKEN_LEN  = {3'd6, 3'd4, 3'd3};
    localparam logic [71:0]      VERSION_TEXT = {"HTTP/1.1", 8'h0D};
    localparam int               VERSION_CHARS = 9;
    localparam logic [2:0]       TOKEN_POS_MAX = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] path;
        logic       ok;
        t_reason    reason;
        logic [8:0] status;
        logic [1:0] method;
    } t_line_result;

    // Parser state of the line in flight
    t_phase     parse_phase;
    logic [2:0] token_pos;
    logic [2:0] token_live;
    logic       last_was_slash;
    logic       path_started;
    logic [3:0] version_pos;
    t_reason    line_fault;
    logic       prior_flag;
    logic       at_line_start;
    logic       token_matched;
    t_method    token_id;

    t_line_result line_results_due [$];

    task automatic restart_line();
        parse_phase    = PH_METHOD;
        token_pos      = '0;
        token_live     = 3'b111;
        last_was_slash = 1'b0;
        path_started   = 1'b0;
        version_pos    = '0;
        line_fault     = RS_OK;
        at_line_start  = 1'b1;
        token_matched  = 1'b0;
        token_id       = M_GET;
    endtask

    // A prior error hides every fault except a missing space
    function automatic t_reason fault_code(input t_reason r);
        if (prior_flag && r != RS_NO_SPACE && r != RS_NO_SP2) begin
            return RS_PRIOR;
        end
        return r;
    endfunction

    function automatic logic [8:0] status_for(input t_reason r);
        case (r)
            RS_NO_SPACE, RS_PATH: return ST_400;
            RS_METHOD:            return ST_405;
            RS_VERSION:           return ST_505;
            default:              return ST_NONE;
        endcase
    endfunction

    task automatic step_line_parser(input logic [7:0] b, input logic eol, input logic prior);
        logic         emit_byte;
        int           hit;
        int           c;
        t_reason      verdict;
        t_line_result res;
        emit_byte = 1'b0;
        if (at_line_start) begin
            prior_flag    = prior;
            at_line_start = 1'b0;
        end
        if (line_fault == RS_OK) begin
            case (parse_phase)
                PH_METHOD: begin
                    if (b == CH_SPACE) begin
                        hit = -1;
                        for (c = 0; c < 3; c++) begin
                            if (token_live[c] && TOKEN_LEN[c] == token_pos) begin
                                hit = c;
                            end
                        end
                        if (hit < 0) begin
                            line_fault = fault_code(RS_METHOD);
                        end else begin
                            token_id      = t_method'(hit);
                            token_matched = 1'b1;
                            parse_phase   = PH_PATH;
                            path_started  = 1'b0;
                        end
                    end else begin
                        for (c = 0; c < 3; c++) begin
                            if (!(token_pos < TOKEN_LEN[c] &&
                                  TOKEN_TEXT[c][47 - 8 * int'(token_pos) -: 8] == b)) begin
                                token_live[c] = 1'b0;
                            end
                        end
                        if (token_pos != TOKEN_POS_MAX) begin
                            token_pos++;
                        end
                    end
                end
                PH_PATH, PH_PATH_BAD: begin
                    if (b == CH_SPACE) begin
                        if (parse_phase == PH_PATH_BAD || !path_started) begin
                            line_fault = fault_code(RS_PATH);
                        end else begin
                            parse_phase = PH_VERSION;
                        end
                    end else if (parse_phase == PH_PATH && !path_started && b != CH_SLASH) begin
                        parse_phase = PH_PATH_BAD;
                    end else if (parse_phase == PH_PATH) begin
                        path_started   = 1'b1;
                        emit_byte      = !(b == CH_SLASH && last_was_slash);
                        last_was_slash = (b == CH_SLASH);
                    end
                end
                default: begin
                    if (version_pos >= VERSION_CHARS ||
                        VERSION_TEXT[71 - 8 * int'(version_pos) -: 8] != b) begin
                        line_fault = fault_code(RS_VERSION);
                    end else begin
                        version_pos++;
                    end
                end
            endcase
        end

        res = '0;
        if (eol) begin
            verdict = line_fault;
            if (verdict == RS_OK) begin
                if (parse_phase == PH_METHOD) begin
                    verdict = RS_NO_SPACE;
                end else if (parse_phase != PH_VERSION) begin
                    verdict = RS_NO_SP2;
                end else if (version_pos != VERSION_CHARS) begin
                    verdict = fault_code(RS_VERSION);
                end
            end
            res.kind   = RK_VERDICT;
            res.ok     = (verdict == RS_OK);
            res.reason = verdict;
            res.status = (verdict == RS_PRIOR) ? ST_NONE : status_for(verdict);
            if (token_matched) begin
                res.method = token_id;
            end
            line_results_due.push_back(res);
            restart_line();
        end else if (emit_byte) begin
            res.kind = RK_PATH;
            res.path = b;
            line_results_due.push_back(res);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    task automatic compare_result();
        t_line_result want;
        if (line_results_due.size() == 0) begin
            $error("result transfer with nothing due (kind %0d)", i_result_kind);
            o_fail_count++;
        end else begin
            want = line_results_due.pop_front();
            check_field("result_kind", want.kind, i_result_kind);
            check_field("path_byte", want.path, i_path_byte);
            check_field("accepted", want.ok, i_accepted);
            check_field("reason", want.reason, i_reason);
            check_field("http_status", want.status, i_http_status);
            check_field("method_code", want.method, i_method_code);
            if (want.kind == RK_VERDICT) begin
                o_lines_seen++;
                if (want.ok) begin
                    o_lines_accepted++;
                end
            end else begin
                o_path_bytes_seen++;
            end
        end
    endtask

    // Compare before predicting: a result never leaves in its own input's cycle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_line();
            prior_flag = 1'b0;
            line_results_due.delete();
            o_fail_count      = 0;
            o_lines_seen      = 0;
            o_lines_accepted  = 0;
            o_path_bytes_seen = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                compare_result();
            end
            if (i_in_valid && !i_in_stall) begin
                step_line_parser(i_line_byte, i_end_of_line, i_prior_error);
            end
        end
        o_results_due <= line_results_due.size();
    end

endmodule

/* sim/http_request_line_checker_core_test.sv */
// ----------------------------------------------------------------------------
// http_request_line_checker_core_test
// Feeds request lines byte by byte: a few short hand-picked lines, then mostly
// well-formed lines with random tokens, paths and prior flags, mixed with
// broken lines and noise. Both channels idle at random; the result side holds
// off once for a long stretch. A side checker predicts and compares results.
// ----------------------------------------------------------------------------
module http_request_line_checker_core_test
    import hrlc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTE_BUDGET = 1950;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = 10;

    // Same token and version tables as the checker; used to build lines
    localparam logic [2:0][47:0] TOKEN_TEXT = {"DELETE", {"POST", 16'h0}, {"GET", 24'h0}};
    localparam logic [2:0][2:0]  TOKEN_LEN  = {3'd6, 3'd4, 3'd3};
    localparam logic [71:0]      VERSION_TEXT = {"HTTP/1.1", 8'h0D};

    // Ways to spoil a well-formed line
    typedef enum int {
        FLAW_TOKEN_CHAR,
        FLAW_LONG_TOKEN,
        FLAW_SHORT_TOKEN,
        FLAW_PATH_START,
        FLAW_EMPTY_PATH,
        FLAW_VERSION_CHAR,
        FLAW_VERSION_SHORT,
        FLAW_VERSION_LONG,
        FLAW_CUT,
        FLAW_NOISE
    } t_flaw;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] line_byte   = '0;
    logic       end_of_line = 1'b0;
    logic       prior_error = 1'b0;
    logic       out_stall   = 1'b0;

    wire logic       in_stall;
    wire logic       out_valid;
    wire logic       result_kind;
    wire logic [7:0] path_byte;
    wire logic       accepted;
    wire logic [2:0] reason;
    wire logic [8:0] http_status;
    wire logic [1:0] method_code;

    int fail_count;
    int results_due;
    int lines_seen;
    int lines_accepted;
    int path_bytes_seen;

    // Bytes of the line being built, and where its two spaces sit
    logic [7:0] line_bytes [$];
    int         first_space;
    int         second_space;

    int bytes_sent    = 0;
    bit no_gaps       = 1'b0;
    bit hold_off_req  = 1'b0;
    bit drain_fault   = 1'b0;

    always #10 clk = ~clk;

    http_request_line_checker_core dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_line_byte   (line_byte),
        .i_end_of_line (end_of_line),
        .i_prior_error (prior_error),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (result_kind),
        .o_path_byte   (path_byte),
        .o_accepted    (accepted),
        .o_reason      (reason),
        .o_http_status (http_status),
        .o_method_code (method_code)
    );

    hrlc_result_checker result_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_line_byte       (line_byte),
        .i_end_of_line     (end_of_line),
        .i_prior_error     (prior_error),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_result_kind     (result_kind),
        .i_path_byte       (path_byte),
        .i_accepted        (accepted),
        .i_reason          (reason),
        .i_http_status     (http_status),
        .i_method_code     (method_code),
        .o_fail_count      (fail_count),
        .o_results_due     (results_due),
        .o_lines_seen      (lines_seen),
        .o_lines_accepted  (lines_accepted),
        .o_path_bytes_seen (path_bytes_seen)
    );

    // Idle length: mostly none or short, now and then long; none at all
    // while a quiet stretch is on
    function automatic int pick_gap();
        int r;
        if (no_gaps) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Offer one byte, idle first if the gap says so, then hold the byte
    // steady until the block takes the transfer
    task automatic send_byte(input logic [7:0] b, input logic eol, input logic prior);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        line_byte   <= b;
        end_of_line <= eol;
        prior_error <= prior;
        do @(posedge clk); while (in_stall);
        bytes_sent++;
    endtask

    // Send the built line; the flag only counts on the first byte, so
    // toggle it at random on the rest
    task automatic send_line(input logic prior);
        int i;
        for (i = 0; i < line_bytes.size(); i++) begin
            send_byte(line_bytes[i], i == line_bytes.size() - 1,
                      (i == 0) ? prior : 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            line_bytes.push_back(s[i]);
        end
    endtask

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    // Well-formed line: token, space, path with slash runs, space, version
    task automatic build_good_line();
        int         m;
        int         i;
        int         n;
        logic [7:0] b;
        line_bytes.delete();
        m = $urandom_range(0, 2);
        for (i = 0; i < TOKEN_LEN[m]; i++) begin
            line_bytes.push_back(TOKEN_TEXT[m][47 - 8 * i -: 8]);
        end
        first_space = line_bytes.size();
        line_bytes.push_back(CH_SPACE);
        line_bytes.push_back(CH_SLASH);
        n = $urandom_range(0, 10);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: b = CH_SLASH;
                3: begin
                    // any byte but a space, to reach every bit of the path
                    do b = 8'($urandom_range(0, 255)); while (b == CH_SPACE);
                end
                default: b = 8'($urandom_range(8'h61, 8'h7A));
            endcase
            line_bytes.push_back(b);
        end
        second_space = line_bytes.size();
        line_bytes.push_back(CH_SPACE);
        for (i = 0; i < 9; i++) begin
            line_bytes.push_back(VERSION_TEXT[71 - 8 * i -: 8]);
        end
    endtask

    task automatic apply_flaw(input t_flaw flaw);
        int pos;
        int n;
        case (flaw)
            FLAW_TOKEN_CHAR: begin
                pos = $urandom_range(0, first_space - 1);
                line_bytes[pos] = line_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            FLAW_LONG_TOKEN: begin
                // at times long enough to run the token position into saturation
                repeat ($urandom_range(1, 6)) line_bytes.insert(first_space, random_letter());
            end
            FLAW_SHORT_TOKEN: begin
                line_bytes.delete(first_space - 1);
            end
            FLAW_PATH_START: begin
                line_bytes[first_space + 1] = random_letter();
            end
            FLAW_EMPTY_PATH: begin
                repeat (second_space - first_space - 1) line_bytes.delete(first_space + 1);
            end
            FLAW_VERSION_CHAR: begin
                pos = $urandom_range(second_space + 1, line_bytes.size() - 1);
                line_bytes[pos] = line_bytes[pos] ^ 8'($urandom_range(1, 255));
            end
            FLAW_VERSION_SHORT: begin
                repeat ($urandom_range(1, 9)) line_bytes.delete(line_bytes.size() - 1);
            end
            FLAW_VERSION_LONG: begin
                repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
            end
            FLAW_CUT: begin
                n = $urandom_range(1, line_bytes.size() - 1);
                while (line_bytes.size() > n) line_bytes.delete(line_bytes.size() - 1);
            end
            default: begin
                // raw noise, with spaces sprinkled in so later phases get hit
                line_bytes.delete();
                repeat ($urandom_range(1, 24)) begin
                    if ($urandom_range(0, 4) == 0) begin
                        line_bytes.push_back(CH_SPACE);
                    end else begin
                        line_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
        endcase
    endtask

    // Result side: random stalls, and once a long hold-off counted here
    initial begin : result_side
        int  gap;
        bit  held;
        held = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Byte side: directed lines, random lines, drain, verdict
    initial begin : byte_side
        int drain;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // No space at all: keeps its own code even with a prior error
        line_bytes.delete();
        push_text("Z");
        send_line(1'b1);
        // Empty token with a prior error: the prior code wins
        line_bytes.delete();
        push_text(" ");
        send_line(1'b1);
        // Line ends on a path byte: only the verdict comes out
        line_bytes.delete();
        push_text("POST /");
        send_line(1'b0);
        // Path without a leading slash, ended by its space
        line_bytes.delete();
        push_text("GET x ");
        send_line(1'b0);
        // Byte extremes
        line_bytes.delete();
        line_bytes.push_back(8'hFF);
        line_bytes.push_back(8'h00);
        send_line(1'b0);
        // Good token, line stops right at the first space
        line_bytes.delete();
        push_text("DELETE ");
        send_line(1'b0);

        // Mostly well-formed lines with random content; the rest broken
        while (bytes_sent < LINE_BYTE_BUDGET) begin
            no_gaps = ($urandom_range(0, 9) == 0);
            build_good_line();
            if ($urandom_range(0, 99) >= 55) begin
                apply_flaw(t_flaw'($urandom_range(FLAW_TOKEN_CHAR, FLAW_NOISE)));
            end
            // halfway through, ask the result side to hold off so the block fills
            if (bytes_sent > LINE_BYTE_BUDGET / 2) begin
                hold_off_req = 1'b1;
            end
            send_line($urandom_range(0, 3) == 0);
        end
        no_gaps = 1'b0;
        in_valid <= 1'b0;

        // Drain: step first so the pending count reflects the last transfer
        drain = 0;
        @(posedge clk);
        while (results_due != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        if (results_due != 0) begin
            $error("%0d results never arrived", results_due);
            drain_fault = 1'b1;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d lines, %0d of them accepted, %0d path bytes",
                 bytes_sent, lines_seen, lines_accepted, path_bytes_seen);
        $display("Random idling on both sides plus one %0d-cycle result hold-off",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0 && !drain_fault) begin
            $display("[http_request_line_checker_core] OK");
        end else begin
            $display("[http_request_line_checker_core] ERROR");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #40_000_000;
        $display("[http_request_line_checker_core] ERROR");
        $finish;
    end

endmodule
